### src/fpalu_pkg.sv
// Package for the fixed-point ALU: item types, action codes and shared helpers.
package fpalu_pkg;

    localparam int DW                 = 32;
    localparam int FRAC_BITS_DEFAULT  = 8;

    localparam logic [3:0] ACT_ADD = 4'd0;
    localparam logic [3:0] ACT_SUB = 4'd1;
    localparam logic [3:0] ACT_MUL = 4'd2;
    localparam logic [3:0] ACT_DIV = 4'd3;
    localparam logic [3:0] ACT_CMP = 4'd4;
    localparam logic [3:0] ACT_MIN = 4'd5;
    localparam logic [3:0] ACT_MAX = 4'd6;
    localparam logic [3:0] ACT_INC = 4'd7;
    localparam logic [3:0] ACT_DEC = 4'd8;
    localparam logic [3:0] ACT_INT = 4'd9;

    typedef struct packed {
        logic [3:0]           action;
        logic signed [DW-1:0] operand_a;
        logic signed [DW-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] result_value;
        logic                 overflow;
        logic                 is_less;
        logic                 is_equal;
        logic                 is_greater;
    } out_t;

    // Operands and product that ride along the divider chain.
    typedef struct packed {
        logic [3:0]             action;
        logic signed [DW-1:0]   operand_a;
        logic signed [DW-1:0]   operand_b;
        logic signed [2*DW-1:0] product;
    } pay_t;

    // Places a sign and magnitude into 32 bits, or falls back to operand A.
    // The result holds the overflow bit above the value.
    function automatic logic [DW:0] place(input logic neg, input logic [2*DW-1:0] mag,
                                          input logic [DW-1:0] a_bits);
        logic          too_big;
        logic [DW-1:0] v;
        too_big = neg ? (mag > {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}})
                      : (mag > {{(DW+1){1'b0}}, {(DW-1){1'b1}}});
        v = neg ? (~mag[DW-1:0] + 1'b1) : mag[DW-1:0];
        return too_big ? {1'b1, a_bits} : {1'b0, v};
    endfunction

endpackage

### src/fpalu_div_cell.sv
// One restoring division step: a cell of the divider chain.
module fpalu_div_cell #(
    parameter int QW = fpalu_pkg::DW + fpalu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  fpalu_pkg::pay_t        in_pay,
    input  logic [fpalu_pkg::DW-1:0] in_rem,
    input  logic [QW-1:0]          in_nq,
    input  logic [fpalu_pkg::DW-1:0] in_mb,
    output logic                   out_valid,
    output fpalu_pkg::pay_t        out_pay,
    output logic [fpalu_pkg::DW-1:0] out_rem,
    output logic [QW-1:0]          out_nq,
    output logic [fpalu_pkg::DW-1:0] out_mb
);

    logic                        valid_reg;
    fpalu_pkg::pay_t             pay_reg;
    logic [fpalu_pkg::DW-1:0]    rem_reg, rem_next, mb_reg;
    logic [QW-1:0]               nq_reg, nq_next;
    logic [fpalu_pkg::DW:0]      trial, diff;
    logic                        ge;

    // Bring down the next numerator bit; the quotient bit enters at the bottom.
    always_comb begin
        trial    = {in_rem, in_nq[QW-1]};
        diff     = trial - {1'b0, in_mb};
        ge       = trial >= {1'b0, in_mb};
        rem_next = ge ? diff[fpalu_pkg::DW-1:0] : trial[fpalu_pkg::DW-1:0];
        nq_next  = {in_nq[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg <= in_pay;
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            mb_reg  <= in_mb;
        end
    end

    assign out_valid = valid_reg;
    assign out_pay   = pay_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_mb    = mb_reg;

endmodule

### src/fixed_point_alu_q24_8_top.sv
// Top level of the signed fixed-point ALU with a pipelined divider chain.
//
//   channel  ports                     direction  payload
//   input    s_valid s_ready s_data    in         fpalu_pkg::in_t
//   result   m_valid m_ready m_data    out        fpalu_pkg::out_t
//
// From acceptance to result, every item passes through one input
// stage, one division cell per quotient bit (32 + FRAC_BITS cells), and the
// output register. A new item is accepted in every cycle unless the chain holds.
// Reset is synchronous and active low; it clears the valid bits of all stages.
// When a result waits and m_ready is low, the whole chain holds and s_ready drops.
module fixed_point_alu_q24_8_top #(
    parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fpalu_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output fpalu_pkg::out_t m_data
);

    localparam int DW = fpalu_pkg::DW;
    // Quotient bits: the numerator is |A| shifted up by the fraction width.
    localparam int QW = DW + FRAC_BITS;

    // The chain advances whenever the output register is empty or drained.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Input stage: the item is captured, the product is formed and the
    // divider is loaded with the magnitudes of both operands.
    logic                v0_reg;
    fpalu_pkg::pay_t     p0_reg, p0_next;
    logic [DW-1:0]       ma_next, mb_next, mb0_reg;
    logic [QW-1:0]       nq0_reg;

    always_comb begin
        p0_next.action    = s_data.action;
        p0_next.operand_a = s_data.operand_a;
        p0_next.operand_b = s_data.operand_b;
        p0_next.product   = s_data.operand_a * s_data.operand_b;
        ma_next = s_data.operand_a[DW-1] ? (~s_data.operand_a + 1'b1) : s_data.operand_a;
        mb_next = s_data.operand_b[DW-1] ? (~s_data.operand_b + 1'b1) : s_data.operand_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_reg  <= p0_next;
            nq0_reg <= {ma_next, {FRAC_BITS{1'b0}}};
            mb0_reg <= mb_next;
        end
    end

    // The chain of division cells; each resolves one quotient bit.
    logic                valid_w [0:QW];
    fpalu_pkg::pay_t     pay_w   [0:QW];
    logic [DW-1:0]       rem_w   [0:QW];
    logic [QW-1:0]       nq_w    [0:QW];
    logic [DW-1:0]       mb_w    [0:QW];

    assign valid_w[0] = v0_reg;
    assign pay_w[0]   = p0_reg;
    assign rem_w[0]   = '0;
    assign nq_w[0]    = nq0_reg;
    assign mb_w[0]    = mb0_reg;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        fpalu_div_cell #(.QW(QW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (valid_w[i]),
            .in_pay    (pay_w[i]),
            .in_rem    (rem_w[i]),
            .in_nq     (nq_w[i]),
            .in_mb     (mb_w[i]),
            .out_valid (valid_w[i+1]),
            .out_pay   (pay_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_nq    (nq_w[i+1]),
            .out_mb    (mb_w[i+1])
        );
    end

    // Output stage: every action's result is finished from the operands,
    // the product and the quotient and remainder at the end of the chain.
    fpalu_pkg::pay_t  pl;
    logic             m_valid_reg;
    fpalu_pkg::out_t  m_data_reg, m_data_next;

    assign pl = pay_w[QW];

    always_comb begin
        logic [DW:0]     sum, dif, incv, decv;
        logic            pneg, rup, ovf_sel;
        logic [2*DW-1:0] pmag, mmag, qmag;
        logic [DW:0]     placed_m, placed_d;
        logic            lt, eq;

        sum  = {pl.operand_a[DW-1], pl.operand_a} + {pl.operand_b[DW-1], pl.operand_b};
        dif  = {pl.operand_a[DW-1], pl.operand_a} - {pl.operand_b[DW-1], pl.operand_b};
        incv = {pl.operand_a[DW-1], pl.operand_a} + 1'b1;
        decv = {pl.operand_a[DW-1], pl.operand_a} - 1'b1;

        // Multiply: round the magnitude to nearest, halves away from zero.
        pneg = pl.product[2*DW-1];
        pmag = pneg ? (~pl.product + 1'b1) : pl.product;
        mmag = (pmag + ({{(2*DW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1))) >> FRAC_BITS;
        placed_m = fpalu_pkg::place(pneg, mmag, pl.operand_a);

        // Divide: round up when twice the remainder reaches the divisor.
        rup  = {rem_w[QW], 1'b0} >= {1'b0, mb_w[QW]};
        qmag = {{(2*DW-QW){1'b0}}, nq_w[QW]} + {{(2*DW-1){1'b0}}, rup};
        placed_d = fpalu_pkg::place(pl.operand_a[DW-1] != pl.operand_b[DW-1], qmag,
                                    pl.operand_a);

        lt = pl.operand_a < pl.operand_b;
        eq = pl.operand_a == pl.operand_b;

        m_data_next.is_less    = lt;
        m_data_next.is_equal   = eq;
        m_data_next.is_greater = !lt && !eq;

        ovf_sel = 1'b0;
        m_data_next.result_value = '0;
        case (pl.action)
            fpalu_pkg::ACT_ADD: begin
                ovf_sel = sum[DW] != sum[DW-1];
                m_data_next.result_value = ovf_sel ? pl.operand_a : sum[DW-1:0];
            end
            fpalu_pkg::ACT_SUB: begin
                ovf_sel = dif[DW] != dif[DW-1];
                m_data_next.result_value = ovf_sel ? pl.operand_a : dif[DW-1:0];
            end
            fpalu_pkg::ACT_MUL: begin
                ovf_sel = placed_m[DW];
                m_data_next.result_value = placed_m[DW-1:0];
            end
            fpalu_pkg::ACT_DIV: begin
                if (pl.operand_b == '0) begin
                    ovf_sel = 1'b1;
                    m_data_next.result_value = pl.operand_a;
                end else begin
                    ovf_sel = placed_d[DW];
                    m_data_next.result_value = placed_d[DW-1:0];
                end
            end
            fpalu_pkg::ACT_CMP: begin
                m_data_next.result_value = '0;
            end
            fpalu_pkg::ACT_MIN: begin
                m_data_next.result_value = lt ? pl.operand_a : pl.operand_b;
            end
            fpalu_pkg::ACT_MAX: begin
                m_data_next.result_value = (!lt && !eq) ? pl.operand_a : pl.operand_b;
            end
            fpalu_pkg::ACT_INC: begin
                ovf_sel = incv[DW] != incv[DW-1];
                m_data_next.result_value = ovf_sel ? pl.operand_a : incv[DW-1:0];
            end
            fpalu_pkg::ACT_DEC: begin
                ovf_sel = decv[DW] != decv[DW-1];
                m_data_next.result_value = ovf_sel ? pl.operand_a : decv[DW-1:0];
            end
            fpalu_pkg::ACT_INT: begin
                // An arithmetic shift rounds toward minus infinity.
                m_data_next.result_value = pl.operand_a >>> FRAC_BITS;
            end
            default: begin
                m_data_next.result_value = '0;
            end
        endcase
        m_data_next.overflow = ovf_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= valid_w[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A delivered item always carries exactly one ordering flag.
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_data.is_less, m_data.is_equal, m_data.is_greater}))
        else $error("ordering flags are not one-hot");

    // A compare item leaves the chain with a zero result and no overflow.
    a_cmp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && valid_w[QW] && pl.action == fpalu_pkg::ACT_CMP
        |=> m_valid && !m_data.overflow && m_data.result_value == '0)
        else $error("compare item produced a nonzero result or overflow");

    // Division by zero returns operand A with overflow raised.
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && valid_w[QW] && pl.action == fpalu_pkg::ACT_DIV && pl.operand_b == '0
        |=> m_data.overflow && m_data.result_value == $past(pl.operand_a))
        else $error("division by zero did not fall back to operand A");

    // While the output stalls, the chain holds its items in place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v0_reg) && $stable(valid_w[QW]))
        else $error("chain moved during a stall");

endmodule

### sim/fixed_point_alu_q24_8_top_tb.sv
// Self-checking testbench for the signed Q24.8 fixed-point ALU.
module fixed_point_alu_q24_8_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = fpalu_pkg::FRAC_BITS_DEFAULT;
    localparam int LATENCY   = FRAC + 34;
    localparam int N_RANDOM  = 1900;
    localparam int HOLD_OFF  = 200;

    // One row of the directed table. When has_gold is set, the expected result
    // is typed in; otherwise the predictor supplies it.
    typedef struct {
        fpalu_pkg::in_t  item;
        logic            has_gold;
        fpalu_pkg::out_t gold;
    } row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    fpalu_pkg::in_t  s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    fpalu_pkg::out_t m_data;

    fpalu_pkg::out_t pending_results[$];
    int   error_count = 0;
    bit   stimulus_done = 1'b0;
    bit   hold_off_req = 1'b0;

    always #5 aclk = ~aclk;

    fixed_point_alu_q24_8_top #(.FRAC_BITS(FRAC)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Fit a sign and magnitude into 32 signed bits, or fall back to operand A.
    function automatic void fit_signed(input bit neg, input logic [63:0] mag,
                                       input logic [31:0] a_bits,
                                       inout fpalu_pkg::out_t r);
        if (neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF)) begin
            r.result_value = a_bits;
            r.overflow = 1'b1;
        end else begin
            r.result_value = neg ? (32'd0 - mag[31:0]) : mag[31:0];
            r.overflow = 1'b0;
        end
    endfunction

    function automatic void fit_wide(input longint v, input logic [31:0] a_bits,
                                     inout fpalu_pkg::out_t r);
        fit_signed(v < 0, (v < 0) ? 64'(-v) : 64'(v), a_bits, r);
    endfunction

    // Predict the ALU result for one item.
    function automatic fpalu_pkg::out_t alu_predict(input fpalu_pkg::in_t it);
        fpalu_pkg::out_t r;
        longint      a;
        longint      b;
        longint      p;
        logic [63:0] mag;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] rem;
        a = longint'(it.operand_a);
        b = longint'(it.operand_b);
        r = '0;
        case (it.action)
            fpalu_pkg::ACT_ADD: fit_wide(a + b, it.operand_a, r);
            fpalu_pkg::ACT_SUB: fit_wide(a - b, it.operand_a, r);
            fpalu_pkg::ACT_MUL: begin
                p = a * b;
                mag = (p < 0) ? 64'(-p) : 64'(p);
                mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
                fit_signed(p < 0, mag, it.operand_a, r);
            end
            fpalu_pkg::ACT_DIV: begin
                if (b == 0) begin
                    r.result_value = it.operand_a;
                    r.overflow = 1'b1;
                end else begin
                    ma = (a < 0) ? 64'(-a) : 64'(a);
                    mb = (b < 0) ? 64'(-b) : 64'(b);
                    q = (ma << FRAC) / mb;
                    rem = (ma << FRAC) % mb;
                    if (2 * rem >= mb) q++;
                    fit_signed((a < 0) != (b < 0), q, it.operand_a, r);
                end
            end
            fpalu_pkg::ACT_CMP: r.result_value = '0;
            fpalu_pkg::ACT_MIN: r.result_value = (a < b) ? it.operand_a : it.operand_b;
            fpalu_pkg::ACT_MAX: r.result_value = (a > b) ? it.operand_a : it.operand_b;
            fpalu_pkg::ACT_INC: fit_wide(a + 1, it.operand_a, r);
            fpalu_pkg::ACT_DEC: fit_wide(a - 1, it.operand_a, r);
            // Arithmetic shift gives floor division by the scale.
            fpalu_pkg::ACT_INT: r.result_value = it.operand_a >>> FRAC;
            default: r.result_value = '0;
        endcase
        r.is_less = a < b;
        r.is_equal = a == b;
        r.is_greater = a > b;
        return r;
    endfunction

    function automatic fpalu_pkg::out_t gold_of(input logic [31:0] v, input logic ovf,
                                                input logic lt, input logic eq,
                                                input logic gt);
        fpalu_pkg::out_t r;
        r.result_value = v;
        r.overflow = ovf;
        r.is_less = lt;
        r.is_equal = eq;
        r.is_greater = gt;
        return r;
    endfunction

    // Offer one item and hold it until the handshake completes.
    task automatic send_item(input fpalu_pkg::in_t it, input fpalu_pkg::out_t exp_r);
        s_data <= it;
        s_valid <= 1'b1;
        pending_results.push_back(exp_r);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return ($urandom_range(0, 2000) - 1000) << FRAC;
            4: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // Directed table plus random items, sent in bursts with random gaps.
    initial begin
        row_t table_rows[$];
        row_t row;
        fpalu_pkg::in_t it;
        int   burst;
        // Reset is held from the start and then released for good.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Compare: value is zero and flags follow the operands.
        table_rows.push_back('{'{fpalu_pkg::ACT_CMP, 32'sd5, 32'sd7}, 1'b1,
                              gold_of(32'h0, 1'b0, 1'b1, 1'b0, 1'b0)});
        table_rows.push_back('{'{fpalu_pkg::ACT_CMP, 32'sd7, 32'sd7}, 1'b1,
                              gold_of(32'h0, 1'b0, 1'b0, 1'b1, 1'b0)});
        // Increment at the top and decrement at the bottom overflow.
        table_rows.push_back('{'{fpalu_pkg::ACT_INC, 32'sh7FFF_FFFF, 32'sd0}, 1'b1,
                              gold_of(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1)});
        table_rows.push_back('{'{fpalu_pkg::ACT_DEC, 32'sh8000_0000, 32'sd0}, 1'b1,
                              gold_of(32'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b0)});
        // Division by zero returns A with overflow.
        table_rows.push_back('{'{fpalu_pkg::ACT_DIV, 32'sh0000_1234, 32'sd0}, 1'b1,
                              gold_of(32'h1234, 1'b1, 1'b0, 1'b0, 1'b1)});
        // Undefined action codes give a zero value and no overflow.
        table_rows.push_back('{'{4'd10, 32'sd1, 32'sd1}, 1'b1,
                              gold_of(32'h0, 1'b0, 1'b0, 1'b1, 1'b0)});
        table_rows.push_back('{'{4'd15, -32'sd1, 32'sd3}, 1'b1,
                              gold_of(32'h0, 1'b0, 1'b1, 1'b0, 1'b0)});
        table_rows.push_back('{'{4'd12, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1,
                              gold_of(32'h0, 1'b0, 1'b0, 1'b0, 1'b1)});
        // To integer floors toward minus infinity.
        table_rows.push_back('{'{fpalu_pkg::ACT_INT, -32'sd1, 32'sd0}, 1'b1,
                              gold_of(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0)});
        table_rows.push_back('{'{fpalu_pkg::ACT_INT, 32'sh8000_0000, 32'sd0}, 1'b0, '0});
        // Extremes on every arithmetic action; predictor checks these.
        table_rows.push_back('{'{fpalu_pkg::ACT_ADD, 32'sh7FFF_FFFF, 32'sd1}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_ADD, 32'sh8000_0000, 32'sh8000_0000},
                              1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_SUB, 32'sh8000_0000, 32'sd1}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_SUB, 32'sd0, 32'sh8000_0000}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_MUL, 32'sh8000_0000, 32'sh8000_0000},
                              1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_MUL, 32'sh0000_0180, -32'sh0000_0080},
                              1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_MUL, 32'sd1, 32'sh0000_0080}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_DIV, 32'sh8000_0000, 32'sd1}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_DIV, 32'sh8000_0000, -32'sd256}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_DIV, 32'sd1, 32'sd3}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_MIN, 32'sh8000_0000, 32'sh7FFF_FFFF},
                              1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF},
                              1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_INC, -32'sd1, 32'sd0}, 1'b0, '0});
        table_rows.push_back('{'{fpalu_pkg::ACT_DEC, 32'sd0, -32'sd1}, 1'b0, '0});

        foreach (table_rows[i]) begin
            row = table_rows[i];
            send_item(row.item, row.has_gold ? row.gold : alu_predict(row.item));
        end

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                it.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                         : 4'($urandom_range(0, 9));
                it.operand_a = rand_operand();
                it.operand_b = ($urandom_range(0, 9) == 0) ? it.operand_a : rand_operand();
                // Keep divisions meaningful: zero divisors only now and then.
                if (it.action == fpalu_pkg::ACT_DIV && it.operand_b == 0 &&
                    $urandom_range(0, 3) != 0)
                    it.operand_b = 32'sd256;
                send_item(it, alu_predict(it));
                // Long receiver hold-off while the sender keeps pushing.
                if (n == 400) hold_off_req = 1'b1;
            end
            // Between items 1000 and 1040, drain the whole pipeline, then go on.
            if (n >= 1000 && n < 1000 + 41) begin
                s_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge aclk);
            end else if ($urandom_range(0, 2) != 0) begin
                idle_gap($urandom_range(1, 30));
            end
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver stalls in its own pattern; a long hold-off is forced once.
    initial begin
        int mode;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        fpalu_pkg::out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_value %h", m_data.result_value);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.result_value !== exp_r.result_value) begin
                    $error("result_value expected %h actual %h",
                           exp_r.result_value, m_data.result_value);
                    error_count++;
                end
                if (m_data.overflow !== exp_r.overflow) begin
                    $error("overflow expected %b actual %b", exp_r.overflow, m_data.overflow);
                    error_count++;
                end
                if (m_data.is_less !== exp_r.is_less) begin
                    $error("is_less expected %b actual %b", exp_r.is_less, m_data.is_less);
                    error_count++;
                end
                if (m_data.is_equal !== exp_r.is_equal) begin
                    $error("is_equal expected %b actual %b", exp_r.is_equal, m_data.is_equal);
                    error_count++;
                end
                if (m_data.is_greater !== exp_r.is_greater) begin
                    $error("is_greater expected %b actual %b",
                           exp_r.is_greater, m_data.is_greater);
                    error_count++;
                end
            end
        end
    end

    // End of run: drain, let the pipeline settle, then report.
    initial begin
        wait (stimulus_done);
        wait (pending_results.size() == 0);
        repeat (2 * LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### fixed_point_alu_q24_8_top.f
src/fpalu_pkg.sv
src/fpalu_div_cell.sv
src/fixed_point_alu_q24_8_top.sv
sim/fixed_point_alu_q24_8_top_tb.sv
